[sv/twsm_pkg.sv]
// ----------------------------------------------------------------------------
// twsm_pkg: shared types and constants for the two-wire sensor master
// Holds the transaction payload types, the configuration set, the
// sequencer phase encoding and the protocol constants.
// ----------------------------------------------------------------------------
package twsm_pkg;

  // Number of clock pulses in a connection reset.
  localparam int RESET_CLOCKS_DEFAULT = 9;

  localparam int HALF_PERIOD_W  = 16;
  localparam int TIMEOUT_W      = 16;
  localparam int COMMAND_W      = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int BIT_INDEX_W    = 4;
  localparam int BYTE_INDEX_W   = 2;
  localparam int ERROR_W        = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_CMD    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUMID_CMD   = 2'd3;

  // Configuration reset values.
  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd250;
  localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RESET     = 16'hFFFF;
  localparam logic [COMMAND_W-1:0]     TEMP_CMD_RESET    = 8'h03;
  localparam logic [COMMAND_W-1:0]     HUMID_CMD_RESET   = 8'h05;

  // Request codes.
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_TEMP  = 2'd1;
  localparam logic [1:0] REQ_HUMID = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  // Protocol constants.
  localparam logic [BIT_INDEX_W-1:0]  BYTE_BITS    = 4'd8;
  localparam logic [BIT_INDEX_W-1:0]  TS_LOW_UNITS = 4'd3;
  localparam logic [BYTE_INDEX_W-1:0] BYTE_COUNT   = 2'd3;
  localparam logic [BYTE_INDEX_W-1:0] ACKED_BYTES  = 2'd2;
  localparam logic [ERROR_W-1:0]      ERROR_MAX    = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_RST_HI = 5'd1,
    PH_RST_LO = 5'd2,
    PH_TS0    = 5'd3,
    PH_TS1    = 5'd4,
    PH_TS2    = 5'd5,
    PH_TS3    = 5'd6,
    PH_TS4    = 5'd7,
    PH_TS5    = 5'd8,
    PH_WR_HI  = 5'd9,
    PH_WR_LO  = 5'd10,
    PH_ACK_HI = 5'd11,
    PH_ACK_LO = 5'd12,
    PH_WAIT   = 5'd13,
    PH_RD_HI  = 5'd14,
    PH_RD_LO  = 5'd15,
    PH_RA_SET = 5'd16,
    PH_RA_HI  = 5'd17,
    PH_RA_LO  = 5'd18
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic               scl;
    logic               sda_release;
    logic               busy_res;
    logic               done_res;
    logic [15:0]        reading;
    logic [7:0]         checksum_byte;
    logic [ERROR_W-1:0] error_count;
  } out_t;

  typedef struct packed {
    logic [HALF_PERIOD_W-1:0] half_period_cycles;
    logic [TIMEOUT_W-1:0]     timeout_units;
    logic [COMMAND_W-1:0]     temperature_command;
    logic [COMMAND_W-1:0]     humidity_command;
  } cfg_t;

endpackage

[sv/twsm_core.sv]
// ----------------------------------------------------------------------------
// twsm_core: bus sequencer of the two-wire sensor master
// Holds the sequencer state and computes one tick of the bus sequence and
// its result from the current state, the request and the sampled data line.
// ----------------------------------------------------------------------------
module twsm_core #(
  parameter int RESET_CLOCKS = twsm_pkg::RESET_CLOCKS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  twsm_pkg::in_t  item,
  input  twsm_pkg::cfg_t cfg,
  output twsm_pkg::out_t result
);

  localparam int BW = twsm_pkg::BIT_INDEX_W;
  localparam int YW = twsm_pkg::BYTE_INDEX_W;
  localparam int EW = twsm_pkg::ERROR_W;

  twsm_pkg::phase_t phase, phase_next;
  logic [15:0]   delay_count, delay_count_next;
  logic [15:0]   wait_count, wait_count_next;
  logic [BW-1:0] bit_index, bit_index_next;
  logic [YW-1:0] byte_index, byte_index_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic [15:0]   reading_reg, reading_reg_next;
  logic [7:0]    checksum_reg, checksum_reg_next;
  logic [EW-1:0] error_reg, error_reg_next;
  logic          reset_seq, reset_seq_next;

  logic [15:0]   unit;
  logic [16:0]   delay_inc;
  logic [15:0]   wait_inc;
  logic [BW-1:0] bit_inc;
  logic [YW-1:0] byte_inc;
  logic [1:0]    lines;
  logic          busy;
  logic          done;

  // Line levels for a phase: bit 1 is the clock, bit 0 is data released.
  function automatic logic [1:0] drive(twsm_pkg::phase_t ph, logic [YW-1:0] byte_idx,
                                       logic wr_bit);
    logic ack_bit;
    ack_bit = (byte_idx < twsm_pkg::ACKED_BYTES) ? 1'b0 : 1'b1;
    unique case (ph)
      twsm_pkg::PH_RST_HI: drive = 2'b11;
      twsm_pkg::PH_TS1:    drive = 2'b11;
      twsm_pkg::PH_TS2:    drive = 2'b10;
      twsm_pkg::PH_TS3:    drive = 2'b00;
      twsm_pkg::PH_TS4:    drive = 2'b10;
      twsm_pkg::PH_TS5:    drive = 2'b11;
      twsm_pkg::PH_WR_HI:  drive = {1'b1, wr_bit};
      twsm_pkg::PH_WR_LO:  drive = {1'b0, wr_bit};
      twsm_pkg::PH_ACK_HI: drive = 2'b11;
      twsm_pkg::PH_RD_HI:  drive = 2'b11;
      twsm_pkg::PH_RA_SET: drive = {1'b0, ack_bit};
      twsm_pkg::PH_RA_HI:  drive = {1'b1, ack_bit};
      twsm_pkg::PH_RA_LO:  drive = {1'b0, ack_bit};
      default:             drive = 2'b01;
    endcase
  endfunction

  assign unit = (cfg.half_period_cycles == '0) ? 16'd1 : cfg.half_period_cycles;

  always_comb begin
    phase_next        = phase;
    delay_count_next  = delay_count;
    wait_count_next   = wait_count;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    shift_byte_next   = shift_byte;
    reading_reg_next  = reading_reg;
    checksum_reg_next = checksum_reg;
    error_reg_next    = error_reg;
    reset_seq_next    = reset_seq;
    busy              = 1'b0;
    done              = 1'b0;
    delay_inc         = '0;
    wait_inc          = '0;
    bit_inc           = '0;
    byte_inc          = '0;

    // A request is taken only when idle.
    if (phase == twsm_pkg::PH_IDLE && item.req_type != twsm_pkg::REQ_NONE) begin
      delay_count_next = '0;
      bit_index_next   = '0;
      byte_index_next  = '0;
      if (item.req_type == twsm_pkg::REQ_RESET) begin
        reset_seq_next = 1'b1;
        phase_next     = twsm_pkg::PH_RST_HI;
      end else begin
        reset_seq_next  = 1'b0;
        error_reg_next  = '0;
        shift_byte_next = (item.req_type == twsm_pkg::REQ_TEMP) ?
                          cfg.temperature_command : cfg.humidity_command;
        phase_next      = twsm_pkg::PH_TS0;
      end
    end

    lines = drive(phase_next, byte_index_next, shift_byte_next[7]);

    if (phase_next != twsm_pkg::PH_IDLE) begin
      busy = 1'b1;
      // Acknowledge and data bits are sampled on the first tick of clock high.
      if (delay_count_next == '0) begin
        if (phase_next == twsm_pkg::PH_ACK_HI && item.sda_in &&
            error_reg_next < twsm_pkg::ERROR_MAX) begin
          error_reg_next = error_reg_next + 1'b1;
        end
        if (phase_next == twsm_pkg::PH_RD_HI) begin
          shift_byte_next = {shift_byte_next[6:0], item.sda_in};
        end
      end
      delay_inc = {1'b0, delay_count_next} + 17'd1;
      bit_inc   = bit_index_next + 1'b1;
      byte_inc  = byte_index_next + 1'b1;
      wait_inc  = wait_count_next + 16'd1;
      if (delay_inc >= {1'b0, unit}) begin
        delay_count_next = '0;
        unique case (phase_next)
          twsm_pkg::PH_RST_HI: phase_next = twsm_pkg::PH_RST_LO;
          twsm_pkg::PH_RST_LO: begin
            if (bit_inc >= BW'(RESET_CLOCKS)) begin
              bit_index_next = '0;
              phase_next     = twsm_pkg::PH_TS0;
            end else begin
              bit_index_next = bit_inc;
              phase_next     = twsm_pkg::PH_RST_HI;
            end
          end
          twsm_pkg::PH_TS0: phase_next = twsm_pkg::PH_TS1;
          twsm_pkg::PH_TS1: phase_next = twsm_pkg::PH_TS2;
          twsm_pkg::PH_TS2: begin
            phase_next     = twsm_pkg::PH_TS3;
            bit_index_next = '0;
          end
          twsm_pkg::PH_TS3: begin
            if (bit_inc >= twsm_pkg::TS_LOW_UNITS) begin
              bit_index_next = '0;
              phase_next     = twsm_pkg::PH_TS4;
            end else begin
              bit_index_next = bit_inc;
            end
          end
          twsm_pkg::PH_TS4: phase_next = twsm_pkg::PH_TS5;
          twsm_pkg::PH_TS5: begin
            if (reset_seq_next) begin
              phase_next = twsm_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next     = twsm_pkg::PH_WR_HI;
              bit_index_next = '0;
            end
          end
          twsm_pkg::PH_WR_HI: phase_next = twsm_pkg::PH_WR_LO;
          twsm_pkg::PH_WR_LO: begin
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            bit_index_next  = bit_inc;
            phase_next      = (bit_inc >= twsm_pkg::BYTE_BITS) ?
                              twsm_pkg::PH_ACK_HI : twsm_pkg::PH_WR_HI;
          end
          twsm_pkg::PH_ACK_HI: phase_next = twsm_pkg::PH_ACK_LO;
          twsm_pkg::PH_ACK_LO: begin
            phase_next      = twsm_pkg::PH_WAIT;
            wait_count_next = '0;
          end
          twsm_pkg::PH_WAIT: begin
            if (!item.sda_in) begin
              phase_next      = twsm_pkg::PH_RD_HI;
              byte_index_next = '0;
              bit_index_next  = '0;
              shift_byte_next = '0;
            end else begin
              wait_count_next = wait_inc;
              if (wait_inc == cfg.timeout_units) begin
                if (error_reg_next < twsm_pkg::ERROR_MAX) begin
                  error_reg_next = error_reg_next + 1'b1;
                end
                phase_next      = twsm_pkg::PH_RD_HI;
                byte_index_next = '0;
                bit_index_next  = '0;
                shift_byte_next = '0;
              end
            end
          end
          twsm_pkg::PH_RD_HI: phase_next = twsm_pkg::PH_RD_LO;
          twsm_pkg::PH_RD_LO: begin
            bit_index_next = bit_inc;
            if (bit_inc >= twsm_pkg::BYTE_BITS) begin
              case (byte_index_next)
                2'd0:    reading_reg_next[15:8] = shift_byte_next;
                2'd1:    reading_reg_next[7:0]  = shift_byte_next;
                default: checksum_reg_next      = shift_byte_next;
              endcase
              phase_next = twsm_pkg::PH_RA_SET;
            end else begin
              phase_next = twsm_pkg::PH_RD_HI;
            end
          end
          twsm_pkg::PH_RA_SET: phase_next = twsm_pkg::PH_RA_HI;
          twsm_pkg::PH_RA_HI:  phase_next = twsm_pkg::PH_RA_LO;
          twsm_pkg::PH_RA_LO: begin
            byte_index_next = byte_inc;
            if (byte_inc >= twsm_pkg::BYTE_COUNT) begin
              phase_next = twsm_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next      = twsm_pkg::PH_RD_HI;
              bit_index_next  = '0;
              shift_byte_next = '0;
            end
          end
          default: begin
            phase_next = twsm_pkg::PH_IDLE;
            done       = 1'b1;
          end
        endcase
      end else begin
        delay_count_next = delay_inc[15:0];
      end
    end

    result.scl           = lines[1];
    result.sda_release   = lines[0];
    result.busy_res      = busy;
    result.done_res      = done;
    result.reading       = reading_reg_next;
    result.checksum_byte = checksum_reg_next;
    result.error_count   = error_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= twsm_pkg::PH_IDLE;
      delay_count  <= '0;
      wait_count   <= '0;
      bit_index    <= '0;
      byte_index   <= '0;
      shift_byte   <= '0;
      reading_reg  <= '0;
      checksum_reg <= '0;
      error_reg    <= '0;
      reset_seq    <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      delay_count  <= delay_count_next;
      wait_count   <= wait_count_next;
      bit_index    <= bit_index_next;
      byte_index   <= byte_index_next;
      shift_byte   <= shift_byte_next;
      reading_reg  <= reading_reg_next;
      checksum_reg <= checksum_reg_next;
      error_reg    <= error_reg_next;
      reset_seq    <= reset_seq_next;
    end
  end

endmodule

[sv/two_wire_sensor_measure_master.sv]
// ----------------------------------------------------------------------------
// two_wire_sensor_measure_master: two-wire humidity/temperature bus master
// Top level: configuration registers, the bus sequencer and the result
// register with its valid/stall handshake.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                          Direction  Carries
//   -------  -------------------------------  ---------  --------------------------
//   in       in_valid, in_stall, in_data      sink       request and sampled data
//   out      out_valid, out_stall, out_data   source     line levels and readings
//   cfg      cfg_we, cfg_index, cfg_wdata     sink       register writes
//
// Each input transaction is one bus tick and yields exactly one output
// transaction in the next cycle; one tick is taken per cycle unless stalled,
// set by the single pass through the sequencer logic into the result register.
// Reset (rst, synchronous) returns the sequencer to idle and loads the
// register defaults. A stalled output holds the result register, and the
// input is stalled only while that register is full and not being taken.
//
// A tick of the bus is one input transaction, not one clock cycle: the bus
// timing (half period, timeout) counts transactions, so the upstream side
// sets the real bus rate by how often it presents ticks.
module two_wire_sensor_measure_master #(
  parameter int RESET_CLOCKS = twsm_pkg::RESET_CLOCKS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input transactions: one tick each.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  twsm_pkg::in_t                       in_data,
  // Output transactions: one result per tick.
  output logic                                out_valid,
  input  logic                                out_stall,
  output twsm_pkg::out_t                      out_data,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [twsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [twsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  twsm_pkg::cfg_t cfg;
  twsm_pkg::out_t result;
  logic           accept;

  // The result register may take a new value when it is empty or when its
  // current contents leave this cycle.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Configuration registers. Write them only while the block is idle; it does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_cycles  <= twsm_pkg::HALF_PERIOD_RESET;
      cfg.timeout_units       <= twsm_pkg::TIMEOUT_RESET;
      cfg.temperature_command <= twsm_pkg::TEMP_CMD_RESET;
      cfg.humidity_command    <= twsm_pkg::HUMID_CMD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        twsm_pkg::CFG_HALF_PERIOD: cfg.half_period_cycles  <= cfg_wdata;
        twsm_pkg::CFG_TIMEOUT:     cfg.timeout_units       <= cfg_wdata;
        twsm_pkg::CFG_TEMP_CMD:    cfg.temperature_command <= cfg_wdata[7:0];
        twsm_pkg::CFG_HUMID_CMD:   cfg.humidity_command    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // The sequencer advances its state only on an accepted transaction.
  twsm_core #(
    .RESET_CLOCKS(RESET_CLOCKS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .item  (in_data),
    .cfg   (cfg),
    .result(result)
  );

  // Result register: the valid flag is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule
